@@ src/dcpw_pkg.sv @@
`timescale 1ns / 1ps

package dcpw_pkg;

  // Default values of the top level parameters.
  localparam int MAX_FOLDS_DEF      = 20;
  localparam int MAX_PPL_DEF        = 64;
  localparam int COORD_WIDTH_DEF    = 24;
  localparam int MAX_FRAME_SIDE_DEF = 4096;

  // Fixed field widths of the configuration registers and the words.
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 3;
  localparam int COLOR_W     = 32;
  localparam int SIDE_W      = 13;
  localparam int PPL_W       = 7;
  localparam int START_W     = 24;
  localparam int DIR_W       = 4;
  localparam int FOLD_W      = 5;
  localparam int INDEX_W     = 24;

  // Register values after reset.
  localparam logic [COLOR_W-1:0]        FILL_COLOR_RST   = 32'hFFE2_08AA;
  localparam logic [SIDE_W-1:0]         FRAME_WIDTH_RST  = 13'd1920;
  localparam logic [SIDE_W-1:0]         FRAME_HEIGHT_RST = 13'd1080;
  localparam logic [PPL_W-1:0]          PPL_RST          = 7'd4;
  localparam logic signed [START_W-1:0] START_X_RST      = 24'sd960;
  localparam logic signed [START_W-1:0] START_Y_RST      = 24'sd540;
  localparam logic [DIR_W-1:0]          START_DIR_RST    = 4'd7;
  localparam logic [FOLD_W-1:0]         FOLD_COUNT_RST   = 5'd10;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FILL_COLOR,
    CFG_FRAME_WIDTH,
    CFG_FRAME_HEIGHT,
    CFG_PIXELS_PER_LINE,
    CFG_START_X,
    CFG_START_Y,
    CFG_START_DIRECTION,
    CFG_FOLD_COUNT
  } cfg_reg_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DRAW
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_start;
    logic prep;
    logic issue;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic last_pixel;
  } status_t;

  // One unit step of the pen.
  typedef struct packed {
    logic signed [1:0] dx;
    logic signed [1:0] dy;
  } heading_t;

  // Direction code (dx+1)*3+(dy+1); codes above eight act as eight.
  function automatic heading_t dir_decode(input logic [DIR_W-1:0] code);
    heading_t h;
    case (code)
      4'd0:    h = '{dx: -2'sd1, dy: -2'sd1};
      4'd1:    h = '{dx: -2'sd1, dy:  2'sd0};
      4'd2:    h = '{dx: -2'sd1, dy:  2'sd1};
      4'd3:    h = '{dx:  2'sd0, dy: -2'sd1};
      4'd4:    h = '{dx:  2'sd0, dy:  2'sd0};
      4'd5:    h = '{dx:  2'sd0, dy:  2'sd1};
      4'd6:    h = '{dx:  2'sd1, dy: -2'sd1};
      4'd7:    h = '{dx:  2'sd1, dy:  2'sd0};
      default: h = '{dx:  2'sd1, dy:  2'sd1};
    endcase
    return h;
  endfunction

endpackage

@@ src/dcpw_if.sv @@
`timescale 1ns / 1ps

// Segment request channel.
interface dcpw_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

// Pixel write channel.
interface dcpw_out_if;
  logic                            valid;
  logic                            ready;
  logic [dcpw_pkg::INDEX_W-1:0]    pixel_index;
  logic                            write_enable;
  logic [dcpw_pkg::COLOR_W-1:0]    color;
  logic                            segment_end;
  logic                            curve_end;

  modport source (output valid, output pixel_index, output write_enable, output color,
                  output segment_end, output curve_end, input ready);
  modport sink   (input valid, input pixel_index, input write_enable, input color,
                  input segment_end, input curve_end, output ready);
endinterface

@@ src/dcpw_ctrl.sv @@
`timescale 1ns / 1ps

module dcpw_ctrl (
  input  logic              clk,
  input  logic              rst,
  dcpw_in_if.sink           segment,
  input  dcpw_pkg::status_t status,
  output dcpw_pkg::cmd_t    cmd
);

  dcpw_pkg::state_t state;
  dcpw_pkg::state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dcpw_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands. A request is taken in idle, the multipliers are
  // loaded in the prepare cycle, then one pixel word leaves per free output slot.
  always_comb begin
    state_next     = state;
    cmd            = '0;
    segment.ready  = 1'b0;
    unique case (state)
      dcpw_pkg::ST_IDLE: begin
        segment.ready  = 1'b1;
        cmd.load_start = segment.valid && segment.restart;
        if (segment.valid) begin
          state_next = dcpw_pkg::ST_PREP;
        end
      end
      dcpw_pkg::ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = dcpw_pkg::ST_DRAW;
      end
      dcpw_pkg::ST_DRAW: begin
        if (status.out_free) begin
          cmd.issue = 1'b1;
          if (status.last_pixel) begin
            state_next = dcpw_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = dcpw_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ src/dcpw_datapath.sv @@
`timescale 1ns / 1ps

module dcpw_datapath #(
  parameter int MAX_FOLDS           = dcpw_pkg::MAX_FOLDS_DEF,
  parameter int MAX_PIXELS_PER_LINE = dcpw_pkg::MAX_PPL_DEF,
  parameter int COORD_WIDTH         = dcpw_pkg::COORD_WIDTH_DEF,
  parameter int MAX_FRAME_SIDE      = dcpw_pkg::MAX_FRAME_SIDE_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [dcpw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dcpw_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  dcpw_pkg::cmd_t                   cmd,
  output dcpw_pkg::status_t                status,
  dcpw_out_if.source                       pixel
);

  localparam int FW    = $clog2(MAX_FRAME_SIDE + 1);
  localparam int CNT_W = $clog2(MAX_PIXELS_PER_LINE + 1);
  localparam int PRW   = COORD_WIDTH + FW + 1;
  localparam int IW    = PRW + 1;
  localparam int SW    = 2 * FW;
  localparam int FCW   = MAX_FOLDS + 1;
  localparam int FOLD_W = dcpw_pkg::FOLD_W;

  localparam logic signed [COORD_WIDTH-1:0] PEN_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] PEN_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam longint PEN_MAX_L = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
  localparam longint PEN_MIN_L = -PEN_MAX_L - 1;

  // Configuration registers.
  logic [dcpw_pkg::COLOR_W-1:0]        fill_color;
  logic [dcpw_pkg::SIDE_W-1:0]         frame_width;
  logic [dcpw_pkg::SIDE_W-1:0]         frame_height;
  logic [dcpw_pkg::PPL_W-1:0]          pixels_per_line;
  logic signed [dcpw_pkg::START_W-1:0] start_x;
  logic signed [dcpw_pkg::START_W-1:0] start_y;
  logic [dcpw_pkg::DIR_W-1:0]          start_direction;
  logic [FOLD_W-1:0]                   fold_count;

  // Walker state.
  logic signed [COORD_WIDTH-1:0] pen_x;
  logic signed [COORD_WIDTH-1:0] pen_y;
  logic signed [1:0]             step_x;
  logic signed [1:0]             step_y;
  logic [MAX_FOLDS-1:0]          seg_cnt;
  logic [CNT_W-1:0]              pix_cnt;

  // Per segment datapath registers.
  logic signed [PRW-1:0] prod;
  logic [SW-1:0]         size;
  logic signed [IW-1:0]  idx;

  // Output register.
  logic                           pix_valid;
  logic [dcpw_pkg::INDEX_W-1:0]   pix_index;
  logic                           pix_we;
  logic [dcpw_pkg::COLOR_W-1:0]   pix_color;
  logic                           pix_seg_end;
  logic                           pix_curve_end;

  // Combinational values.
  logic [FW-1:0]                 width_c;
  logic [FW-1:0]                 height_c;
  logic [CNT_W-1:0]              ppl_c;
  logic [FOLD_W-1:0]             folds_c;
  logic [FCW-1:0]                last_seg;
  logic                          final_seg;
  logic [FCW-1:0]                seg_num;
  logic [FCW-1:0]                seg_low;
  logic                          turn_r;
  logic signed [COORD_WIDTH-1:0] start_pen_x;
  logic signed [COORD_WIDTH-1:0] start_pen_y;
  dcpw_pkg::heading_t            start_head;
  dcpw_pkg::heading_t            reset_head;
  logic                          sat_x;
  logic                          sat_y;
  logic signed [1:0]             dx_eff;
  logic signed [1:0]             dy_eff;
  logic signed [FW:0]            w_prod;
  logic signed [IW-1:0]          w_s;
  logic signed [IW-1:0]          row_delta;
  logic signed [IW-1:0]          idx_delta;
  logic signed [IW-1:0]          cur_idx;
  logic signed [IW-1:0]          size_s;
  logic                          in_frame;
  logic signed [1:0]             turn_x;
  logic signed [1:0]             turn_y;

  // Saturate a start coordinate into the pen range.
  function automatic logic signed [COORD_WIDTH-1:0] sat_start(
    input logic signed [dcpw_pkg::START_W-1:0] v
  );
    logic signed [COORD_WIDTH-1:0] r;
    if (longint'(v) > PEN_MAX_L) begin
      r = PEN_MAX;
    end else if (longint'(v) < PEN_MIN_L) begin
      r = PEN_MIN;
    end else begin
      r = COORD_WIDTH'(v);
    end
    return r;
  endfunction

  // Clamp the registers to the supported ranges.
  always_comb begin
    width_c  = (32'(frame_width) > 32'(MAX_FRAME_SIDE)) ? FW'(MAX_FRAME_SIDE)
                                                        : FW'(frame_width);
    height_c = (32'(frame_height) > 32'(MAX_FRAME_SIDE)) ? FW'(MAX_FRAME_SIDE)
                                                         : FW'(frame_height);
    if (pixels_per_line == '0) begin
      ppl_c = CNT_W'(1);
    end else if (32'(pixels_per_line) > 32'(MAX_PIXELS_PER_LINE)) begin
      ppl_c = CNT_W'(MAX_PIXELS_PER_LINE);
    end else begin
      ppl_c = CNT_W'(pixels_per_line);
    end
    folds_c = (fold_count > FOLD_W'(MAX_FOLDS)) ? FOLD_W'(MAX_FOLDS) : fold_count;
  end

  // Last segment of the curve and the paperfolding turn bit.
  always_comb begin
    last_seg  = (FCW'(1) << folds_c) - FCW'(1);
    final_seg = ({1'b0, seg_cnt} >= last_seg);
    seg_num   = {1'b0, seg_cnt} + FCW'(1);
    seg_low   = seg_num & (~seg_num + FCW'(1));
    turn_r    = ((seg_num & (seg_low << 1)) == '0);
  end

  // Start values.
  always_comb begin
    start_pen_x = sat_start(start_x);
    start_pen_y = sat_start(start_y);
    start_head  = dcpw_pkg::dir_decode(start_direction);
    reset_head  = dcpw_pkg::dir_decode(dcpw_pkg::START_DIR_RST);
  end

  // Pen step with saturation; the linear index follows the step that is taken.
  always_comb begin
    sat_x     = (pen_x == PEN_MAX && step_x == 2'sd1) || (pen_x == PEN_MIN && step_x == -2'sd1);
    sat_y     = (pen_y == PEN_MAX && step_y == 2'sd1) || (pen_y == PEN_MIN && step_y == -2'sd1);
    dx_eff    = sat_x ? 2'sd0 : step_x;
    dy_eff    = sat_y ? 2'sd0 : step_y;
    w_prod    = signed'({1'b0, width_c});
    w_s       = IW'(w_prod);
    if (dy_eff == 2'sd1) begin
      row_delta = w_s;
    end else if (dy_eff == -2'sd1) begin
      row_delta = -w_s;
    end else begin
      row_delta = '0;
    end
    idx_delta = IW'(dx_eff) + row_delta;
    cur_idx   = (pix_cnt == '0) ? (IW'(pen_x) + IW'(prod)) : idx;
    size_s    = signed'(IW'(size));
    in_frame  = !cur_idx[IW-1] && (cur_idx < size_s);
  end

  // Quarter turn at the end of a segment.
  always_comb begin
    if (step_x != 2'sd0) begin
      turn_x = 2'sd0;
      if (step_x == 2'sd1) begin
        turn_y = turn_r ? -2'sd1 : 2'sd1;
      end else begin
        turn_y = turn_r ? 2'sd1 : -2'sd1;
      end
    end else begin
      turn_y = 2'sd0;
      if (step_y == 2'sd1) begin
        turn_x = turn_r ? 2'sd1 : -2'sd1;
      end else begin
        turn_x = turn_r ? -2'sd1 : 2'sd1;
      end
    end
  end

  // Status for the controller.
  always_comb begin
    status.out_free   = !pix_valid || pixel.ready;
    status.last_pixel = (pix_cnt == ppl_c - CNT_W'(1));
  end

  // Configuration registers and walker state.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_color      <= dcpw_pkg::FILL_COLOR_RST;
      frame_width     <= dcpw_pkg::FRAME_WIDTH_RST;
      frame_height    <= dcpw_pkg::FRAME_HEIGHT_RST;
      pixels_per_line <= dcpw_pkg::PPL_RST;
      start_x         <= dcpw_pkg::START_X_RST;
      start_y         <= dcpw_pkg::START_Y_RST;
      start_direction <= dcpw_pkg::START_DIR_RST;
      fold_count      <= dcpw_pkg::FOLD_COUNT_RST;
      pen_x           <= sat_start(dcpw_pkg::START_X_RST);
      pen_y           <= sat_start(dcpw_pkg::START_Y_RST);
      step_x          <= reset_head.dx;
      step_y          <= reset_head.dy;
      seg_cnt         <= '0;
      pix_cnt         <= '0;
      pix_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (dcpw_pkg::cfg_reg_t'(cfg_index))
          dcpw_pkg::CFG_FILL_COLOR:      fill_color      <= cfg_data;
          dcpw_pkg::CFG_FRAME_WIDTH:     frame_width     <= cfg_data[dcpw_pkg::SIDE_W-1:0];
          dcpw_pkg::CFG_FRAME_HEIGHT:    frame_height    <= cfg_data[dcpw_pkg::SIDE_W-1:0];
          dcpw_pkg::CFG_PIXELS_PER_LINE: pixels_per_line <= cfg_data[dcpw_pkg::PPL_W-1:0];
          dcpw_pkg::CFG_START_X:         start_x         <= cfg_data[dcpw_pkg::START_W-1:0];
          dcpw_pkg::CFG_START_Y:         start_y         <= cfg_data[dcpw_pkg::START_W-1:0];
          dcpw_pkg::CFG_START_DIRECTION: start_direction <= cfg_data[dcpw_pkg::DIR_W-1:0];
          dcpw_pkg::CFG_FOLD_COUNT:      fold_count      <= cfg_data[FOLD_W-1:0];
          default: begin
          end
        endcase
      end

      // A restart reloads the pen before the segment is drawn.
      if (cmd.load_start) begin
        pen_x   <= start_pen_x;
        pen_y   <= start_pen_y;
        step_x  <= start_head.dx;
        step_y  <= start_head.dy;
        seg_cnt <= '0;
      end else if (cmd.issue) begin
        // Each issued word moves the pen; the last one turns or wraps the curve.
        pix_cnt <= status.last_pixel ? '0 : pix_cnt + CNT_W'(1);
        if (status.last_pixel && final_seg) begin
          pen_x   <= start_pen_x;
          pen_y   <= start_pen_y;
          step_x  <= start_head.dx;
          step_y  <= start_head.dy;
          seg_cnt <= '0;
        end else begin
          pen_x <= pen_x + COORD_WIDTH'(dx_eff);
          pen_y <= pen_y + COORD_WIDTH'(dy_eff);
          if (status.last_pixel) begin
            step_x  <= turn_x;
            step_y  <= turn_y;
            seg_cnt <= seg_cnt + MAX_FOLDS'(1);
          end
        end
      end

      // Output word valid flag.
      if (cmd.issue) begin
        pix_valid <= 1'b1;
      end else if (pixel.ready) begin
        pix_valid <= 1'b0;
      end
    end
  end

  // Row product, frame size, running index and the output word.
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      prod <= PRW'(pen_y) * PRW'(w_prod);
      size <= SW'(width_c) * SW'(height_c);
    end
    if (cmd.issue) begin
      idx           <= cur_idx + idx_delta;
      pix_index     <= in_frame ? cur_idx[dcpw_pkg::INDEX_W-1:0] : '0;
      pix_we        <= in_frame;
      pix_color     <= fill_color;
      pix_seg_end   <= status.last_pixel;
      pix_curve_end <= status.last_pixel && final_seg;
    end
  end

  assign pixel.valid        = pix_valid;
  assign pixel.pixel_index  = pix_index;
  assign pixel.write_enable = pix_we;
  assign pixel.color        = pix_color;
  assign pixel.segment_end  = pix_seg_end;
  assign pixel.curve_end    = pix_curve_end;

`ifndef SYNTHESIS
  // A word is never loaded over one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> (!pix_valid || pixel.ready))
    else $error("output word overwritten before it was taken");

  // A disabled write carries index zero.
  a_disabled_zero: assert property (@(posedge clk) disable iff (rst)
    pix_valid && !pix_we |-> pix_index == '0)
    else $error("disabled write with non-zero index");

  // The final segment brings the counter back to zero.
  a_wrap: assert property (@(posedge clk) disable iff (rst)
    cmd.issue && status.last_pixel && final_seg |=> seg_cnt == '0)
    else $error("segment counter did not wrap after the final segment");

  // After a turn the heading lies on one axis.
  a_axis: assert property (@(posedge clk) disable iff (rst)
    cmd.issue && status.last_pixel && !final_seg |=> (step_x == 2'sd0) != (step_y == 2'sd0))
    else $error("heading not axis aligned after a turn");
`endif

endmodule

@@ src/dragon_curve_pixel_walker_unit.sv @@
`timescale 1ns / 1ps

// Heighway dragon curve pixel walker. Each word on the segment channel draws
// one segment of the curve as pixels_per_line pixel words, each giving the
// linear frame index x + y * width, a write enable that is set only when the
// index lies inside the frame, and the fill colour; the last word of a run
// carries segment_end, and of the curve's final segment also curve_end, after
// which the pen, heading and segment counter return to their start values.
// A segment word with restart set reloads those start values first; writing a
// register alone does not move the pen. The user must write the registers
// through the cfg port only while idle; the block itself does not enforce it.
// Each request is taken in the idle state, the two multipliers form the row
// product and the frame size in the prepare state, then one pixel word per
// cycle goes into the output register, unless the pixel channel holds ready
// low. The next request is taken while the last pixel word still waits there.
module dragon_curve_pixel_walker_unit #(
  parameter int MAX_FOLDS           = dcpw_pkg::MAX_FOLDS_DEF,
  parameter int MAX_PIXELS_PER_LINE = dcpw_pkg::MAX_PPL_DEF,
  parameter int COORD_WIDTH         = dcpw_pkg::COORD_WIDTH_DEF,
  parameter int MAX_FRAME_SIDE      = dcpw_pkg::MAX_FRAME_SIDE_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  dcpw_in_if.sink                          segment,
  dcpw_out_if.source                       pixel,
  input  logic                             cfg_we,
  input  logic [dcpw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dcpw_pkg::CFG_DATA_W-1:0]  cfg_data
);

  dcpw_pkg::cmd_t    cmd;
  dcpw_pkg::status_t status;

  // Sequencer.
  dcpw_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .segment (segment),
    .status  (status),
    .cmd     (cmd)
  );

  // Registers, pen arithmetic and output word.
  dcpw_datapath #(
    .MAX_FOLDS           (MAX_FOLDS),
    .MAX_PIXELS_PER_LINE (MAX_PIXELS_PER_LINE),
    .COORD_WIDTH         (COORD_WIDTH),
    .MAX_FRAME_SIDE      (MAX_FRAME_SIDE)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .pixel     (pixel)
  );

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import dcpw_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam longint COORD_MAX = (longint'(1) << (COORD_WIDTH_DEF - 1)) - 1;
  localparam longint COORD_MIN = -COORD_MAX - 1;

  // One pixel write word as the block should present it.
  typedef struct {
    logic [INDEX_W-1:0] pixel_index;
    logic               write_enable;
    logic [COLOR_W-1:0] color;
    logic               segment_end;
    logic               curve_end;
  } pixel_word_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  dcpw_in_if  seg_if ();
  dcpw_out_if pix_if ();

  dragon_curve_pixel_walker_unit dut (
    .clk       (clk),
    .rst       (rst),
    .segment   (seg_if),
    .pixel     (pix_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Register copies held by the walker model.
  logic [COLOR_W-1:0]        fill_reg;
  logic [SIDE_W-1:0]         width_reg;
  logic [SIDE_W-1:0]         height_reg;
  logic [PPL_W-1:0]          ppl_reg;
  logic signed [START_W-1:0] start_x_reg;
  logic signed [START_W-1:0] start_y_reg;
  logic [DIR_W-1:0]          dir_reg;
  logic [FOLD_W-1:0]         folds_reg;

  // Pen, heading and segment counter of the model.
  logic signed [START_W-1:0] pen_x;
  logic signed [START_W-1:0] pen_y;
  logic signed [1:0]         step_dx;
  logic signed [1:0]         step_dy;
  logic [19:0]               seg_count;

  pixel_word_t pixel_words_due[$];
  logic        segment_requests[$];
  int          requests_queued = 0;
  int          requests_taken = 0;
  int          mismatches = 0;
  int          src_idle_pct = 0;
  int          sink_stall_pct = 0;
  int unsigned cycle_count = 0;
  logic        seg_fire = 1'b0;

  // Move one coordinate by one step, clamped to the signed coordinate range.
  function automatic logic signed [START_W-1:0] coord_step(
      input logic signed [START_W-1:0] c, input logic signed [1:0] d);
    longint s;
    s = longint'(c) + longint'(d);
    if (s > COORD_MAX) s = COORD_MAX;
    else if (s < COORD_MIN) s = COORD_MIN;
    return s[START_W-1:0];
  endfunction

  // Put the pen back at its start position and heading.
  function automatic void home_pen();
    int unsigned code;
    code = (dir_reg > 4'd8) ? 8 : int'(dir_reg);
    pen_x = start_x_reg;
    pen_y = start_y_reg;
    step_dx = 2'(int'(code / 3) - 1);
    step_dy = 2'(int'(code % 3) - 1);
    seg_count = '0;
  endfunction

  // Work out the pixel words of one segment, then turn or wrap the curve.
  function automatic void walk_segment(input logic restart);
    int unsigned folds, last_no, ppl, w, h, m, lowest, p;
    longint      frame_area, idx;
    bit          last_seg, turn_r, en;
    pixel_word_t pw;
    if (restart) home_pen();
    folds = (folds_reg > MAX_FOLDS_DEF) ? MAX_FOLDS_DEF : folds_reg;
    last_no = (32'd1 << folds) - 1;
    last_seg = (seg_count >= last_no);
    ppl = (ppl_reg == 0) ? 1 : ppl_reg;
    if (ppl > MAX_PPL_DEF) ppl = MAX_PPL_DEF;
    w = (width_reg > MAX_FRAME_SIDE_DEF) ? MAX_FRAME_SIDE_DEF : width_reg;
    h = (height_reg > MAX_FRAME_SIDE_DEF) ? MAX_FRAME_SIDE_DEF : height_reg;
    frame_area = longint'(w) * longint'(h);
    for (p = 0; p < ppl; p++) begin
      idx = longint'(pen_x) + longint'(pen_y) * longint'(w);
      en = (idx >= 0) && (idx < frame_area);
      pw.pixel_index = en ? idx[INDEX_W-1:0] : '0;
      pw.write_enable = en;
      pw.color = fill_reg;
      pw.segment_end = (p == ppl - 1);
      pw.curve_end = pw.segment_end && last_seg;
      pixel_words_due.push_back(pw);
      pen_x = coord_step(pen_x, step_dx);
      pen_y = coord_step(pen_y, step_dy);
    end
    if (last_seg) begin
      home_pen();
      return;
    end
    // Paperfolding bit: with m = 2^k * odd, turn right when bit 1 of odd is 0.
    m = seg_count + 1;
    lowest = m & (~m + 1);
    turn_r = ((m & (lowest << 1)) == 0);
    if (step_dx != 0) begin
      if (step_dx == 2'sd1) step_dy = turn_r ? -2'sd1 : 2'sd1;
      else step_dy = turn_r ? 2'sd1 : -2'sd1;
      step_dx = 2'sd0;
    end else begin
      if (step_dy == 2'sd1) step_dx = turn_r ? 2'sd1 : -2'sd1;
      else step_dx = turn_r ? -2'sd1 : 2'sd1;
      step_dy = 2'sd0;
    end
    seg_count = seg_count + 1'b1;
  endfunction

  // Write one register; bits above its width carry noise the block must drop.
  task automatic put_reg(input cfg_reg_t idx, input logic [31:0] val);
    int          width;
    logic [31:0] mask;
    case (idx)
      CFG_FILL_COLOR:                   width = COLOR_W;
      CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT: width = SIDE_W;
      CFG_PIXELS_PER_LINE:              width = PPL_W;
      CFG_START_X, CFG_START_Y:         width = START_W;
      CFG_START_DIRECTION:              width = DIR_W;
      default:                          width = FOLD_W;
    endcase
    mask = (width >= 32) ? 32'hFFFF_FFFF : ((32'd1 << width) - 1);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= (val & mask) | ($urandom & ~mask);
    case (idx)
      CFG_FILL_COLOR:      fill_reg = val;
      CFG_FRAME_WIDTH:     width_reg = val[SIDE_W-1:0];
      CFG_FRAME_HEIGHT:    height_reg = val[SIDE_W-1:0];
      CFG_PIXELS_PER_LINE: ppl_reg = val[PPL_W-1:0];
      CFG_START_X:         start_x_reg = val[START_W-1:0];
      CFG_START_Y:         start_y_reg = val[START_W-1:0];
      CFG_START_DIRECTION: dir_reg = val[DIR_W-1:0];
      default:             folds_reg = val[FOLD_W-1:0];
    endcase
  endtask

  task automatic close_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input logic [31:0] fill, w, h, ppl, sx, sy, dir, folds);
    put_reg(CFG_FILL_COLOR, fill);
    put_reg(CFG_FRAME_WIDTH, w);
    put_reg(CFG_FRAME_HEIGHT, h);
    put_reg(CFG_PIXELS_PER_LINE, ppl);
    put_reg(CFG_START_X, sx);
    put_reg(CFG_START_Y, sy);
    put_reg(CFG_START_DIRECTION, dir);
    put_reg(CFG_FOLD_COUNT, folds);
    close_writes();
  endtask

  // Mostly small frames and short runs; now and then an empty or oversized one.
  task automatic random_config();
    logic [31:0] w, h, ppl, sx, sy, folds;
    case ($urandom_range(9))
      0:       w = 0;
      1:       w = $urandom_range(4096, 8191);
      default: w = $urandom_range(1, 64);
    endcase
    case ($urandom_range(9))
      0:       h = 0;
      1:       h = $urandom_range(4096, 8191);
      default: h = $urandom_range(1, 64);
    endcase
    case ($urandom_range(9))
      0:       ppl = 0;
      1:       ppl = $urandom_range(64, 127);
      default: ppl = $urandom_range(1, 8);
    endcase
    sx = ($urandom_range(7) == 0) ? $urandom : $urandom_range(0, 72) - 8;
    sy = ($urandom_range(7) == 0) ? $urandom : $urandom_range(0, 72) - 8;
    folds = ($urandom_range(4) == 0) ? $urandom_range(6, 31) : $urandom_range(0, 5);
    set_config($urandom, w, h, ppl, sx, sy, $urandom_range(15), folds);
  endtask

  task automatic send(input logic restart);
    segment_requests.push_back(restart);
    requests_queued++;
  endtask

  // Random segments: long runs without restart so curves reach their end.
  task automatic send_random(input int n);
    int i;
    for (i = 0; i < n; i++) send($urandom_range(7) == 0);
  endtask

  // Wait until every request is taken and every pixel word has come out.
  task automatic settle();
    while (requests_taken != requests_queued || pixel_words_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Segment driver: a new word goes out only after the previous one was taken.
  always @(negedge clk) begin
    if (rst) begin
      seg_if.valid <= 1'b0;
      seg_if.restart <= 1'b0;
    end else if (!seg_if.valid || seg_fire) begin
      if (segment_requests.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        seg_if.valid <= 1'b1;
        seg_if.restart <= segment_requests.pop_front();
      end else begin
        seg_if.valid <= 1'b0;
        seg_if.restart <= 1'($urandom_range(1));
      end
    end
  end

  // Each accepted segment word is run through the model at once.
  always @(posedge clk) begin
    seg_fire <= !rst && seg_if.valid && seg_if.ready;
    if (!rst && seg_if.valid && seg_if.ready) begin
      walk_segment(seg_if.restart);
      requests_taken++;
    end
  end

  // Pixel receiver stalls at random.
  always @(negedge clk) begin
    pix_if.ready <= !rst && ($urandom_range(99) >= sink_stall_pct);
  end

  // Monitor: every accepted pixel word is matched against the oldest one due.
  always @(posedge clk) begin
    pixel_word_t want;
    if (!rst && pix_if.valid && pix_if.ready) begin
      if (pixel_words_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: pixel word with none due: idx=%h we=%b col=%h se=%b ce=%b",
                   $realtime, pix_if.pixel_index, pix_if.write_enable, pix_if.color,
                   pix_if.segment_end, pix_if.curve_end);
      end else begin
        want = pixel_words_due.pop_front();
        if (want.pixel_index !== pix_if.pixel_index ||
            want.write_enable !== pix_if.write_enable ||
            want.color !== pix_if.color ||
            want.segment_end !== pix_if.segment_end ||
            want.curve_end !== pix_if.curve_end) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: pixel word mismatch: expected idx=%h we=%b col=%h se=%b ce=%b",
                     $realtime, want.pixel_index, want.write_enable, want.color,
                     want.segment_end, want.curve_end, "; got idx=%h we=%b col=%h se=%b ce=%b",
                     pix_if.pixel_index, pix_if.write_enable, pix_if.color,
                     pix_if.segment_end, pix_if.curve_end);
        end
      end
    end
  end

  // Watchdog on a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("dragon_curve_pixel_walker_unit regression: fail");
      $finish;
    end
  end

  initial begin
    int k;
    seg_if.valid = 1'b0;
    seg_if.restart = 1'b0;
    pix_if.ready = 1'b0;
    fill_reg = FILL_COLOR_RST;
    width_reg = FRAME_WIDTH_RST;
    height_reg = FRAME_HEIGHT_RST;
    ppl_reg = PPL_RST;
    start_x_reg = START_X_RST;
    start_y_reg = START_Y_RST;
    dir_reg = START_DIR_RST;
    folds_reg = FOLD_COUNT_RST;
    home_pen();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Settings after reset, with a restart partway through.
    send(1'b0);
    send(1'b0);
    send(1'b1);
    send(1'b0);
    settle();

    // Largest frame with the pen on its last pixel, diagonal heading, one segment.
    set_config(32'h0, 4096, 4096, 1, 4095, 4095, 0, 0);
    send(1'b1);
    send(1'b0);
    settle();

    // Empty frame, zero run length, direction and fold count past their limits.
    set_config(32'hFFFF_FFFF, 0, 5, 0, 32'h0080_0000, 32'h007F_FFFF, 15, 31);
    send(1'b1);
    send(1'b0);
    settle();

    // Oversized sides and run, pen pinned at the negative corner, two segments.
    set_config(32'h5A5A_A5A5, 8191, 8191, 127, 32'h0080_0000, 32'h0080_0000, 1, 1);
    send(1'b1);
    send(1'b0);
    send(1'b0);
    settle();

    // Zero heading turns like a vertical one.
    set_config(32'h1234_5678, 16, 16, 3, 8, 8, 4, 3);
    send(1'b1);
    send(1'b0);
    send(1'b0);
    send(1'b0);
    settle();

    // Fold count lowered in the middle of a curve ends it on the next segment.
    set_config(32'hC3C3_3C3C, 32, 32, 2, 16, 16, 5, 5);
    send(1'b1);
    repeat (5) send(1'b0);
    settle();
    put_reg(CFG_FOLD_COUNT, 1);
    close_writes();
    send(1'b0);
    send(1'b0);
    settle();

    // Random settings; the sender also pauses midway until every word is out.
    for (k = 0; k < 10; k++) begin
      case (k % 4)
        0: begin
          src_idle_pct = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct = 87;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct = 0;
          sink_stall_pct = 87;
        end
        default: begin
          src_idle_pct = 13;
          sink_stall_pct = 13;
        end
      endcase
      random_config();
      send_random(12);
      settle();
      send_random(13);
      settle();
    end

    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("dragon_curve_pixel_walker_unit regression: pass");
    end else begin
      $display("dragon_curve_pixel_walker_unit regression: fail");
    end
    $finish;
  end

endmodule
